@@ rtl/bounded_bag_insert_query_remove_top_assert.svh @@
// ----------------------------------------------------------------------------
// Bounded bag assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BAG_INSERT_QUERY_REMOVE_TOP_ASSERT_SVH
`define BOUNDED_BAG_INSERT_QUERY_REMOVE_TOP_ASSERT_SVH

`ifndef SYNTH
// Plain property, sampled on the rising clock, off during reset.
`define BBAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in this cycle implies a consequence in the next one.
`define BBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BBAG_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/bbag_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded bag package
// Sizes, request codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package bbag_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CW1     = CW + 1;
  localparam int CAP_W   = 7;
  localparam int FILL_W  = 7;
  localparam int VAL_W   = 32;
  localparam int REQ_W   = 2;
  localparam int CMP_W   = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;       // latch request, clear index and flag
    logic ins;        // append key at count, bump count, set flag
    logic set_ok;     // set success flag
    logic rd_scan;    // read entry at index
    logic rd_shift;   // read entry at index + 1
    logic wr_shift;   // move read entry down to index, advance index
    logic idx_inc;    // advance index
    logic dec_count;  // drop one from count
    logic publish;    // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             cnt_zero;
    logic             can_ins;
    logic             hit;
    logic             last;   // index + 1 reaches count
    logic             last2;  // index + 2 reaches count
    logic [CW-1:0]    count;
  } dp_status_t;

endpackage

@@ rtl/bbag_dp.sv @@
// ----------------------------------------------------------------------------
// Bounded bag datapath
// Entry memory, count, capacity, scan index and result register.
// ----------------------------------------------------------------------------
module bbag_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bbag_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic [bbag_pkg::REQ_W-1:0]  in_req_type,
  input  logic signed [bbag_pkg::VAL_W-1:0] in_value,
  input  bbag_pkg::ctrl_cmd_t         cmd,
  output bbag_pkg::dp_status_t        sts,
  output logic                        out_success,
  output logic [bbag_pkg::FILL_W-1:0] out_fill_count
);
  import bbag_pkg::*;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rd_data_r;
  logic [CW-1:0]     count_r;
  logic [CAP_W-1:0]  cap_r;
  logic [REQ_W-1:0]  req_r;
  logic [VAL_W-1:0]  key_r;
  logic [AW-1:0]     idx_r;
  logic              ok_r;
  logic              out_success_r;
  logic [FILL_W-1:0] out_fill_count_r;

  logic [CW1-1:0]    idx_p1;
  logic [CW1-1:0]    idx_p2;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  assign idx_p1 = CW1'(idx_r) + CW1'(1);
  assign idx_p2 = CW1'(idx_r) + CW1'(2);

  assign wr_en   = cmd.ins | cmd.wr_shift;
  assign wr_addr = cmd.ins ? count_r[AW-1:0] : idx_r;
  assign wr_data = cmd.ins ? key_r : rd_data_r;
  assign rd_en   = cmd.rd_scan | cmd.rd_shift;
  assign rd_addr = cmd.rd_shift ? idx_p1[AW-1:0] : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state: count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.ins) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= in_value;
      idx_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (cmd.ins || cmd.set_ok) begin
        ok_r <= 1'b1;
      end
      if (cmd.idx_inc || cmd.wr_shift) begin
        idx_r <= idx_r + AW'(1);
      end
    end
    if (cmd.publish) begin
      out_success_r    <= ok_r;
      out_fill_count_r <= FILL_W'(count_r);
    end
  end

  assign sts.req      = req_r;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.can_ins  = (CMP_W'(count_r) < CMP_W'(cap_r)) && (count_r < CW'(DEPTH));
  assign sts.hit      = (rd_data_r == key_r);
  assign sts.last     = (idx_p1 >= CW1'(count_r));
  assign sts.last2    = (idx_p2 >= CW1'(count_r));
  assign sts.count    = count_r;

  assign out_success    = out_success_r;
  assign out_fill_count = out_fill_count_r;

endmodule

@@ rtl/bbag_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded bag controller
// Sequences insert, scan and shift steps; owns both handshakes.
// ----------------------------------------------------------------------------
module bbag_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bbag_pkg::dp_status_t sts,
  output bbag_pkg::ctrl_cmd_t  cmd
);
  import bbag_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.req) inside
          REQ_INSERT: begin
            cmd.ins   = sts.can_ins;
            state_nxt = ST_FINISH;
          end
          REQ_QUERY, REQ_REMOVE: begin
            state_nxt = sts.cnt_zero ? ST_FINISH : ST_SCAN_RD;
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.hit) begin
          if (sts.req == REQ_REMOVE && !sts.last) begin
            state_nxt = ST_SHIFT_RD;
          end else begin
            cmd.set_ok    = 1'b1;
            cmd.dec_count = (sts.req == REQ_REMOVE);
            state_nxt     = ST_FINISH;
          end
        end else if (sts.last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        if (sts.last2) begin
          cmd.set_ok    = 1'b1;
          cmd.dec_count = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          state_nxt = ST_SHIFT_RD;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/bounded_bag_insert_query_remove_top.sv @@
// ----------------------------------------------------------------------------
// Bounded bag, insert / query / remove
// Unsorted packed bag of signed 32-bit values with a configurable capacity.
// ----------------------------------------------------------------------------
//
//  channel | ports                                      | dir
//  --------+--------------------------------------------+-----
//  request | in_valid, in_stall, in_req_type, in_value  | in
//  result  | out_valid, out_stall, out_success,         | out
//          | out_fill_count                             |
//  config  | cfg_wr_en, cfg_wr_data (capacity)          | in
//
//  Steps per request: an insert or unknown code, or a query/remove on an empty
//  bag, goes through dispatch and finish; a query reads and compares entries
//  one at a time up to the first match or the end; a remove then reads and
//  writes each later entry to shift it down. Each step reads at most one entry.
//  Reset (rst_n low, synchronous) empties the bag and sets capacity to 64.
//  A stalled result holds in the output register; the next request is still
//  taken and runs until its own result needs that register.
//
`include "bounded_bag_insert_query_remove_top_assert.svh"

module bounded_bag_insert_query_remove_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bbag_pkg::CAP_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bbag_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [bbag_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_success,
  output logic [bbag_pkg::FILL_W-1:0]       out_fill_count
);
  import bbag_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer: walks each request through its steps, owns valid and stall
  bbag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and compare: entries, count, capacity, result register
  bbag_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_success    (out_success),
    .out_fill_count (out_fill_count)
  );

  // fill count never passes the entry store size
  `BBAG_ASSERT(a_count_bound, clk, rst_n, sts.count <= CW'(DEPTH), "count above DEPTH")

  // an accepted beat makes the sequencer busy in the next cycle
  `BBAG_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")

  // count moves by at most one per cycle
  `BBAG_ASSERT(a_count_step, clk, rst_n, !$past(rst_n) || sts.count == $past(sts.count) || sts.count == $past(sts.count) + CW'(1) || sts.count == $past(sts.count) - CW'(1), "count jumped")

  // a result is loaded only when the output register is free or draining
  `BBAG_ASSERT(a_publish_free, clk, rst_n, !cmd.publish || !out_valid || !out_stall, "result overwritten")

endmodule

@@ bench/tb_bounded_bag_insert_query_remove_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded bag insert / query / remove testbench
// Drives insert, query, remove and unused requests through the valid/stall
// request channel. A shadow bag predicts the success flag and fill count of
// every request, and the result stream is checked beat by beat against it.
// The capacity register is swept between phases, with random idling on both
// channels except in the closing phase.
// ----------------------------------------------------------------------------
module tb_bounded_bag_insert_query_remove_top;
  import bbag_pkg::*;

  // Request code 3 is not a member of req_t; the block treats it as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Slowest correct request: remove of the first of 64 entries, plus the
  // longest gap and the longest stall, for about 1300 beats.
  // Allow several times that.
  localparam int CYCLE_LIMIT  = 1_500_000;
  // Settle time after the last result, above the longest remove.
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic              success;
    logic [FILL_W-1:0] fill_count;
  } bag_result_t;

  // Block ports; the inputs are at known values from time zero.
  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_wr_en      = 1'b0;
  logic [CAP_W-1:0]         cfg_wr_data    = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type    = '0;
  logic signed [VAL_W-1:0]  in_value       = '0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic                     out_success;
  logic [FILL_W-1:0]        out_fill_count;

  // Shadow copy of the bag: stored values in arrival order and the capacity.
  logic [VAL_W-1:0] shadow_bag[$];
  logic [CAP_W-1:0] shadow_cap = CAP_RESET;

  // Results predicted for accepted requests, oldest first.
  bag_result_t pending_results[$];

  int  errors      = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  // Random idling on both channels; cleared for the closing phase.
  bit  idle_on     = 1'b1;

  bounded_bag_insert_query_remove_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success),
    .out_fill_count (out_fill_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result-side stalls: random bursts. Only one
  // nonblocking write per edge, so compute the next level first.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 12) begin
      stall_left = $urandom_range(1, 13);
    end
    out_stall <= (stall_left != 0);
  end

  // Check every accepted result beat against the oldest prediction.
  // Values read here are the ones present at the edge.
  always @(posedge clk) begin : result_check
    bag_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: success=%0b fill_count=%0d",
               out_success, out_fill_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_success !== want.success) begin
          $error("success: expected %0b, got %0b", want.success, out_success);
          errors++;
        end
        if (out_fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, out_fill_count);
          errors++;
        end
      end
    end
  end

  // Position of the first stored value equal to key, or -1.
  function automatic int bag_find(input logic [VAL_W-1:0] key);
    for (int i = 0; i < shadow_bag.size(); i++) begin
      if (shadow_bag[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow bag and return the result it yields.
  function automatic bag_result_t bag_apply(input logic [REQ_W-1:0] op,
                                            input logic [VAL_W-1:0] key);
    bag_result_t r;
    int          limit;
    int          pos;
    r.success = 1'b0;
    // Capacity above DEPTH saturates; zero blocks every insert.
    limit = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    case (op)
      REQ_INSERT: begin
        if (shadow_bag.size() < limit) begin
          shadow_bag.push_back(key);
          r.success = 1'b1;
        end
      end
      REQ_QUERY: begin
        r.success = (bag_find(key) >= 0);
      end
      REQ_REMOVE: begin
        // Drop the first match; later values move down one place.
        pos = bag_find(key);
        if (pos >= 0) begin
          shadow_bag.delete(pos);
          r.success = 1'b1;
        end
      end
      default: begin
        // Unused code: no change, count still reported.
      end
    endcase
    r.fill_count = FILL_W'(shadow_bag.size());
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pool_key(input int idx);
    case (idx)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h0000_0100;
    endcase
  endfunction

  // Mostly keys that are stored or likely to repeat, so queries and removes
  // hit often and duplicates pile up; the rest is fully random.
  function automatic logic [VAL_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && shadow_bag.size() != 0)
      return shadow_bag[$urandom_range(0, shadow_bag.size() - 1)];
    if (sel < 7)
      return pool_key($urandom_range(0, 7));
    return $urandom;
  endfunction

  // Send one request beat. Called right after a rising edge; returns right
  // after the edge that took the beat, with in_valid still high so that a
  // back-to-back beat never lowers and raises it in the same step.
  task automatic bag_request(input logic [REQ_W-1:0] op, input logic [VAL_W-1:0] key);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_value    <= key;
    // Hold the payload until an edge sees valid with no stall.
    do @(posedge clk); while (in_stall);
    pending_results.push_back(bag_apply(op, key));
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write capacity with the block idle. Every request yields a result, so an
  // empty prediction store means nothing is in flight.
  task automatic cfg_set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_cap = cap;
  endtask

  // Query, remove and the unused code on an empty bag.
  task automatic test_empty_bag();
    bag_request(REQ_QUERY, 32'h0000_0000);
    bag_request(REQ_REMOVE, 32'h0000_0000);
    bag_request(REQ_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Store the value extremes, with one duplicate.
  task automatic test_insert_extremes();
    bag_request(REQ_INSERT, 32'h8000_0000);
    bag_request(REQ_INSERT, 32'h7FFF_FFFF);
    bag_request(REQ_INSERT, 32'h0000_0000);
    bag_request(REQ_INSERT, 32'hFFFF_FFFF);
    bag_request(REQ_INSERT, 32'h7FFF_FFFF);
  endtask

  task automatic test_query_hits();
    bag_request(REQ_QUERY, 32'h7FFF_FFFF);
    bag_request(REQ_QUERY, 32'h0000_0001);
    bag_request(REQ_QUERY, 32'hFFFF_FFFF);
  endtask

  // First-match removal, a miss, removal at the front, a query, then a no-op.
  task automatic test_remove_first_match();
    bag_request(REQ_REMOVE, 32'h7FFF_FFFF);
    bag_request(REQ_REMOVE, 32'd12345);
    bag_request(REQ_REMOVE, 32'h8000_0000);
    bag_request(REQ_QUERY, 32'h7FFF_FFFF);
    bag_request(REQ_UNUSED, 32'h0000_0000);
  endtask

  // Capacity below the count, at the count, zero, and above DEPTH.
  task automatic test_capacity_limits();
    cfg_set_capacity(7'd2);
    bag_request(REQ_INSERT, 32'h0000_0011);
    bag_request(REQ_REMOVE, 32'h0000_0000);
    bag_request(REQ_INSERT, 32'h0000_0012);
    bag_request(REQ_REMOVE, 32'hFFFF_FFFF);
    bag_request(REQ_INSERT, 32'h0000_002A);
    cfg_set_capacity(7'd0);
    bag_request(REQ_INSERT, 32'h0000_002B);
    cfg_set_capacity(7'd127);
    bag_request(REQ_INSERT, 32'h0000_002C);
  endtask

  // Random requests; ins_pct and rem_pct steer the fill level up or down.
  task automatic test_random_walk(input int n, input int ins_pct, input int rem_pct);
    int               roll;
    logic [REQ_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)                          op = REQ_UNUSED;
      else if (roll < 3 + ins_pct)           op = REQ_INSERT;
      else if (roll < 3 + ins_pct + rem_pct) op = REQ_REMOVE;
      else                                   op = REQ_QUERY;
      bag_request(op, pick_key());
    end
  endtask

  initial begin
    // Hold reset, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_bag();
    test_insert_extremes();
    test_query_hits();
    test_remove_first_match();
    test_capacity_limits();

    // Fill to DEPTH and beyond at the reset capacity, then at the top code.
    cfg_set_capacity(CAP_RESET);
    test_random_walk(300, 65, 15);
    cfg_set_capacity(7'd127);
    test_random_walk(200, 60, 20);
    // Tiny capacity, mostly at or below the count it inherits.
    cfg_set_capacity(7'd1);
    test_random_walk(100, 30, 50);
    // No inserts may land; drain what is left.
    cfg_set_capacity(7'd0);
    test_random_walk(80, 30, 50);
    for (int k = 0; k < 3; k++) begin
      cfg_set_capacity(CAP_W'($urandom_range(1, 127)));
      test_random_walk(120, 45, 35);
    end

    // Closing phase: full rate on both channels.
    cfg_set_capacity(CAP_RESET);
    idle_on = 1'b0;
    test_random_walk(200, 50, 30);

    wait_drained();
    // Catch any stray result beat after the last one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
